>>> rtl/sfd_pkg.sv
// Shared constants, types and helpers for the smoothed feedback delay.
package sfd_pkg;

    localparam int LINE_DEPTH = 262144;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int FILL_W     = $clog2(LINE_DEPTH + 1);

    localparam int SAMPLE_W   = 24;
    localparam int DELAY_W    = 18;
    localparam int GAIN_W     = 17;
    localparam int FRAC_W     = 24;
    localparam int SMOOTH_W   = DELAY_W + FRAC_W;
    localparam int DIFF_W     = SMOOTH_W + 1;
    localparam int GAIN_SHIFT = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam int MUL_W      = 26;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CMP_W      = ((ADDR_W > DELAY_W) ? ADDR_W : DELAY_W) + 1;

    // 0.0002 in Q0.24
    localparam logic signed [MUL_W-1:0] SMOOTH_COEF = 26'sd3355;

    localparam logic [DELAY_W-1:0] DELAY_TARGET_RST = 18'd24000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BYPASS       = 2'd0,
        REG_DELAY_TARGET = 2'd1,
        REG_FEEDBACK     = 2'd2,
        REG_MIX          = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SM_HI,
        ST_SM_LO,
        ST_SM_UPD,
        ST_ADDR,
        ST_RD_B,
        ST_SUB,
        ST_INTERP,
        ST_READ,
        ST_FB,
        ST_MIX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                    en;
        logic signed [MUL_W-1:0] op_a;
        logic signed [MUL_W-1:0] op_b;
    } mul_req_t;

    typedef struct packed {
        logic                       en;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] data;
    } line_wr_t;

    // clamp a wide signed value to the 24-bit sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [PROD_W:0] v
    );
        logic [PROD_W-SAMPLE_W+1:0] top;
        top = v[PROD_W:SAMPLE_W-1];
        if (top == '0 || top == '1) begin
            return v[SAMPLE_W-1:0];
        end else if (v[PROD_W]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> rtl/sfd_mul.sv
// Shared signed multiplier with registered product.
module sfd_mul
    import sfd_pkg::*;
(
    input  logic                     aclk,
    input  mul_req_t                 req,
    output logic signed [PROD_W-1:0] product
);

    logic signed [PROD_W-1:0] product_reg;

    // product holds while no new request arrives
    always_ff @(posedge aclk) begin
        if (req.en) begin
            product_reg <= req.op_a * req.op_b;
        end
    end

    assign product = product_reg;

endmodule

>>> rtl/sfd_line.sv
// Delay line storage: one write port, one registered read port.
module sfd_line
    import sfd_pkg::*;
(
    input  logic                       aclk,
    input  line_wr_t                   wr,
    input  logic [ADDR_W-1:0]          raddr,
    output logic signed [SAMPLE_W-1:0] rdata
);

    logic signed [SAMPLE_W-1:0] mem [LINE_DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/smoothed_feedback_delay.sv
// Top level: feedback delay echo with one-pole smoothed delay time.
// Active item: after accept, SM_HI, SM_LO, SM_UPD, ADDR, RD_B, SUB, INTERP, READ, FB, MIX, DONE.
// Bypass item: goes straight to DONE. Next accept only in IDLE, once DONE has loaded the result.
// The sequencing follows the one shared multiplier (5 products) and the single read port.
// Synchronous active-low reset clears control, pointer, smoother and fill count;
// delay line entries not yet written since reset read as zero via the fill count.
module smoothed_feedback_delay
    import sfd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    state_t state_reg, state_next;

    logic                bypass_reg;
    logic [DELAY_W-1:0]  target_reg;
    logic [GAIN_W-1:0]   feedback_reg;
    logic [GAIN_W-1:0]   mix_reg;

    logic [SMOOTH_W-1:0] smoothed_reg, smoothed_next;
    logic [ADDR_W-1:0]   wp_reg, wp_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic [ADDR_W-1:0]          ib_reg;
    logic                       va_reg;
    logic                       vb_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W:0]   ba_reg;
    logic signed [SAMPLE_W-1:0] rd_reg;

    mul_req_t                   mul_req;
    logic signed [PROD_W-1:0]   mul_prod;
    line_wr_t                   line_wr;
    logic [ADDR_W-1:0]          line_raddr;
    logic signed [SAMPLE_W-1:0] line_rdata;
    logic                       out_load;

    logic signed [DIFF_W-1:0]   diff_comb;
    logic signed [PROD_W-1:0]   smooth_sum;
    logic signed [PROD_W-1:0]   interp_frac;
    logic signed [PROD_W:0]     fb_sum;
    logic signed [PROD_W:0]     mix_sum;
    logic [CMP_W-1:0]           ip_wide;
    logic [ADDR_W-1:0]          ip;
    logic [ADDR_W:0]            sum_a;
    logic [ADDR_W-1:0]          ia_comb;
    logic [ADDR_W-1:0]          ib_comb;
    logic                       fill_full;
    logic                       va_comb;
    logic                       vb_comb;
    logic signed [SAMPLE_W-1:0] b_val;

    sfd_mul u_mul (
        .aclk    (aclk),
        .req     (mul_req),
        .product (mul_prod)
    );

    sfd_line u_line (
        .aclk  (aclk),
        .wr    (line_wr),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg   <= 1'b1;
            target_reg   <= DELAY_TARGET_RST;
            feedback_reg <= '0;
            mix_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BYPASS:       bypass_reg   <= cfg_data[0];
                REG_DELAY_TARGET: target_reg   <= cfg_data[DELAY_W-1:0];
                REG_FEEDBACK:     feedback_reg <= cfg_data[GAIN_W-1:0];
                REG_MIX:          mix_reg      <= cfg_data[GAIN_W-1:0];
            endcase
        end
    end

    // ---------------- datapath arithmetic ----------------
    assign diff_comb = $signed({1'b0, target_reg, {FRAC_W{1'b0}}})
                     - $signed({1'b0, smoothed_reg});

    // smoothed += hi*coef + floor(lo*coef / 2^24)
    assign smooth_sum  = PROD_W'($signed({1'b0, smoothed_reg})) + acc_reg
                       + (mul_prod >>> FRAC_W);
    assign interp_frac = mul_prod >>> FRAC_W;
    assign fb_sum      = (PROD_W+1)'(mul_prod >>> GAIN_SHIFT) + (PROD_W+1)'(x_reg);
    assign mix_sum     = (PROD_W+1)'(mul_prod >>> GAIN_SHIFT) + (PROD_W+1)'(x_reg);
    assign b_val       = vb_reg ? line_rdata : '0;

    // tap addresses, integer delay clamped to the last line address (LINE_DEPTH - 1)
    always_comb begin
        ip_wide = CMP_W'(smoothed_reg[SMOOTH_W-1:FRAC_W]);
        if (ip_wide >= CMP_W'(LINE_DEPTH)) begin
            ip = ADDR_W'(LINE_DEPTH - 1);
        end else begin
            ip = ip_wide[ADDR_W-1:0];
        end
        sum_a = (ADDR_W+1)'(wp_reg) + (ADDR_W+1)'(ip);
        if (sum_a >= (ADDR_W+1)'(LINE_DEPTH)) begin
            ia_comb = ADDR_W'(sum_a - (ADDR_W+1)'(LINE_DEPTH));
        end else begin
            ia_comb = sum_a[ADDR_W-1:0];
        end
        if (ia_comb == ADDR_W'(LINE_DEPTH - 1)) begin
            ib_comb = '0;
        end else begin
            ib_comb = ia_comb + 1'b1;
        end
        // written slots sit at offsets 1..fill ahead of the write pointer
        fill_full = (fill_reg == FILL_W'(LINE_DEPTH));
        va_comb   = fill_full || (ip != '0 && FILL_W'(ip) <= fill_reg);
        vb_comb   = fill_full || (ip != ADDR_W'(LINE_DEPTH - 1)
                                  && (FILL_W'(ip) + FILL_W'(1)) <= fill_reg);
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = bypass_reg ? ST_DONE : ST_SM_HI;
                end
            end
            ST_SM_HI:  state_next = ST_SM_LO;
            ST_SM_LO:  state_next = ST_SM_UPD;
            ST_SM_UPD: state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_SUB;
            ST_SUB:    state_next = ST_INTERP;
            ST_INTERP: state_next = ST_READ;
            ST_READ:   state_next = ST_FB;
            ST_FB:     state_next = ST_MIX;
            ST_MIX:    state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        mul_req    = '0;
        line_wr    = '0;
        out_load   = 1'b0;
        line_raddr = (state_reg == ST_RD_B) ? ib_reg : ia_comb;
        unique case (state_reg)
            ST_SM_HI: begin
                mul_req = '{1'b1, MUL_W'($signed(diff_reg[DIFF_W-1:FRAC_W])), SMOOTH_COEF};
            end
            ST_SM_LO: begin
                mul_req = '{1'b1, MUL_W'($signed({1'b0, diff_reg[FRAC_W-1:0]})),
                            SMOOTH_COEF};
            end
            ST_INTERP: begin
                mul_req = '{1'b1, MUL_W'(ba_reg),
                            MUL_W'($signed({1'b0, smoothed_reg[FRAC_W-1:0]}))};
            end
            ST_FB: begin
                mul_req = '{1'b1, MUL_W'($signed({1'b0, feedback_reg})), MUL_W'(rd_reg)};
            end
            ST_MIX: begin
                mul_req = '{1'b1, MUL_W'($signed({1'b0, mix_reg})), MUL_W'(rd_reg)};
                line_wr = '{1'b1, wp_reg, sat_sample(fb_sum)};
            end
            ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_comb begin
        smoothed_next = smoothed_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        if (state_reg == ST_SM_UPD) begin
            smoothed_next = smooth_sum[SMOOTH_W-1:0];
        end
        if (line_wr.en) begin
            wp_next = (wp_reg == '0) ? ADDR_W'(LINE_DEPTH - 1) : wp_reg - 1'b1;
            if (fill_reg != FILL_W'(LINE_DEPTH)) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            smoothed_reg <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            smoothed_reg <= smoothed_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg    <= s_sample_in;
            diff_reg <= diff_comb;
        end
        if (state_reg == ST_SM_LO) begin
            acc_reg <= mul_prod;
        end
        if (state_reg == ST_ADDR) begin
            ib_reg <= ib_comb;
            va_reg <= va_comb;
            vb_reg <= vb_comb;
        end
        if (state_reg == ST_RD_B) begin
            a_reg <= va_reg ? line_rdata : '0;
        end
        if (state_reg == ST_SUB) begin
            ba_reg <= (SAMPLE_W+1)'(b_val) - (SAMPLE_W+1)'(a_reg);
        end
        if (state_reg == ST_READ) begin
            rd_reg <= a_reg + $signed(interp_frac[SAMPLE_W-1:0]);
        end
        if (out_load) begin
            m_sample_reg <= bypass_reg ? x_reg : sat_sample(mix_sum);
        end
    end

    // ---------------- assertions ----------------
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(LINE_DEPTH))
        else $error("fill count beyond line depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("result load did not raise m_valid");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !bypass_reg) |=> (state_reg == ST_SM_HI && !s_ready))
        else $error("active transaction did not start the smoother");

endmodule

>>> tb/smoothed_feedback_delay_check.sv
`timescale 1ns / 100ps
// Checker for the smoothed feedback delay: predicts each output sample and compares it.
module smoothed_feedback_delay_check
    import sfd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_in,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_sample_out,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         mismatches,
    output int                         outstanding,
    output int                         compared
);

    localparam longint PEAK_POS   = 64'sd8388607;
    localparam longint PEAK_NEG   = -64'sd8388608;
    localparam longint GLIDE_COEF = 64'sd3355;

    // model of the echo line; 2-state so it starts at zero, as unwritten line entries read
    bit signed [SAMPLE_W-1:0]   echo_line [LINE_DEPTH];
    logic [ADDR_W-1:0]          wr_ptr;
    logic [SMOOTH_W-1:0]        glide_delay;
    logic                       bypass_q;
    logic [DELAY_W-1:0]         target_q;
    logic [GAIN_W-1:0]          feedback_q;
    logic [GAIN_W-1:0]          mix_q;

    logic signed [SAMPLE_W-1:0] pending_out [$];
    logic signed [SAMPLE_W-1:0] oldest;
    int                         errs = 0;
    int                         n_cmp = 0;

    function automatic logic signed [SAMPLE_W-1:0] clip24(input longint v);
        if (v > PEAK_POS) begin
            return SAMPLE_W'(PEAK_POS);
        end else if (v < PEAK_NEG) begin
            return SAMPLE_W'(PEAK_NEG);
        end
        return SAMPLE_W'(v);
    endfunction

    // one sample through the echo (bypass returns it as is): glide the delay, read between two taps, write back
    function automatic logic signed [SAMPLE_W-1:0] echo_sample(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint dry, gap, tap_int, tap_frac, tap_a, tap_b, wet;
        int     ia, ib;
        dry = x;
        if (bypass_q) begin
            return x;
        end
        gap = longint'({target_q, {FRAC_W{1'b0}}}) - longint'(glide_delay);
        glide_delay = SMOOTH_W'(longint'(glide_delay) + ((gap * GLIDE_COEF) >>> FRAC_W));

        tap_int  = longint'(glide_delay >> FRAC_W);
        tap_frac = longint'(glide_delay[FRAC_W-1:0]);
        if (tap_int >= LINE_DEPTH) begin
            tap_int = LINE_DEPTH - 1;
        end
        ia    = int'((longint'(wr_ptr) + tap_int) % LINE_DEPTH);
        ib    = int'((longint'(wr_ptr) + tap_int + 1) % LINE_DEPTH);
        tap_a = echo_line[ia];
        tap_b = echo_line[ib];
        wet   = tap_a + (((tap_b - tap_a) * tap_frac) >>> FRAC_W);

        echo_line[wr_ptr] = clip24(dry + ((longint'(feedback_q) * wet) >>> GAIN_SHIFT));
        wr_ptr = wr_ptr - 1'b1;
        return clip24(dry + ((longint'(mix_q) * wet) >>> GAIN_SHIFT));
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr      = '0;
            glide_delay = '0;
            bypass_q    = 1'b1;
            target_q    = DELAY_TARGET_RST;
            feedback_q  = '0;
            mix_q       = '0;
            pending_out.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_BYPASS:       bypass_q   = cfg_data[0];
                    REG_DELAY_TARGET: target_q   = cfg_data[DELAY_W-1:0];
                    REG_FEEDBACK:     feedback_q = cfg_data[GAIN_W-1:0];
                    REG_MIX:          mix_q      = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                pending_out.push_back(echo_sample(s_sample_in));
            end
            if (m_valid && m_ready) begin
                if (pending_out.size() == 0) begin
                    errs++;
                    if (errs <= 10) begin
                        $display("unexpected output transaction: sample_out %0d", m_sample_out);
                    end
                end else begin
                    oldest = pending_out.pop_front();
                    n_cmp++;
                    if (m_sample_out !== oldest) begin
                        errs++;
                        if (errs <= 10) begin
                            $display("sample_out mismatch #%0d: expected %0d, got %0d",
                                     n_cmp, oldest, m_sample_out);
                        end
                    end
                end
            end
        end
        mismatches  <= errs;
        outstanding <= pending_out.size();
        compared    <= n_cmp;
    end

endmodule

>>> tb/smoothed_feedback_delay_test.sv
`timescale 1ns / 100ps
// Testbench top for the smoothed feedback delay: stimulus, register settings, verdict.
module smoothed_feedback_delay_test;
    import sfd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 24;     // time for an active sample to complete, plus margin

    localparam logic signed [SAMPLE_W-1:0] MAX_S = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] MIN_S = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [GAIN_W-1:0]          GAIN_ONE = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0]          GAIN_TOP = '1;
    localparam logic [DELAY_W-1:0]         DELAY_TOP = '1;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_BYPASS;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    logic steady = 1'b0;
    int   hold_requests = 0;
    int   hold_taken = 0;
    int   hold_left = 0;
    int   cycles = 0;
    int   samples_sent = 0;
    int   settings_used = 0;
    int   mismatches, outstanding, compared;

    smoothed_feedback_delay u_dut (.*);

    smoothed_feedback_delay_check u_check (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side: random back-pressure unless steady, long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_requests) begin
            hold_taken <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 32);
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            case ($urandom_range(0, 3))
                0:       return MAX_S;
                1:       return MIN_S;
                2:       return '0;
                default: return '1;
            endcase
        end else if (roll < 25) begin
            return SAMPLE_W'($urandom_range(0, 4095)) - SAMPLE_W'(2048);
        end
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        while (!steady && $urandom_range(0, 99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
    endtask

    task automatic apply_settings(input logic bypass, input logic [DELAY_W-1:0] target,
                                  input logic [GAIN_W-1:0] fb, input logic [GAIN_W-1:0] mix);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BYPASS;
        cfg_data  <= CFG_DATA_W'(bypass);
        @(posedge aclk);
        cfg_index <= REG_DELAY_TARGET;
        cfg_data  <= target;
        @(posedge aclk);
        cfg_index <= REG_FEEDBACK;
        cfg_data  <= CFG_DATA_W'(fb);
        @(posedge aclk);
        cfg_index <= REG_MIX;
        cfg_data  <= CFG_DATA_W'(mix);
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // stop offering and wait for every outstanding output, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int count);
        repeat (count) send_sample(pick_sample());
    endtask

    initial begin
        logic [DELAY_W-1:0] target;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bypass is on out of reset: extremes pass straight through
        send_sample(MAX_S);
        send_sample(MIN_S);
        send_sample('0);
        send_sample('1);
        send_sample(24'sh555555);
        send_sample(24'shAAAAAA);
        drain();

        // one-sample target, unity gains: delay stays under one sample and the
        // newest tap leaks in through the fraction, full-scale input saturates
        apply_settings(1'b0, DELAY_W'(1), GAIN_ONE, GAIN_ONE);
        repeat (4) send_sample(MAX_S);
        repeat (4) send_sample(MIN_S);
        send_sample('0);
        send_sample(SAMPLE_W'(1));
        drain();

        // gains past unity, longest target
        apply_settings(1'b0, DELAY_TOP, GAIN_TOP, GAIN_TOP);
        repeat (3) send_sample(MAX_S);
        repeat (3) send_sample(MIN_S);
        drain();

        // no idling on either side
        apply_settings(1'b0, DELAY_W'(2), GAIN_ONE, GAIN_ONE);
        steady <= 1'b1;
        run_phase(60);
        drain();
        steady <= 1'b0;

        // long output stall while input keeps coming
        apply_settings(1'b0, DELAY_W'(3), GAIN_W'(49152), GAIN_W'(32768));
        hold_requests <= hold_requests + 1;
        run_phase(60);
        drain();

        apply_settings(1'b0, DELAY_W'(2400), GAIN_ONE, '0);
        run_phase(50);
        drain();

        apply_settings(1'b0, '0, GAIN_TOP, GAIN_TOP);
        run_phase(50);
        drain();

        // bypass with odd values loaded: state must stay frozen
        apply_settings(1'b1, DELAY_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
        run_phase(40);
        drain();

        repeat (5) begin
            target = ($urandom_range(0, 1) != 0) ? DELAY_W'($urandom_range(0, 16))
                                                 : DELAY_W'($urandom);
            apply_settings(($urandom_range(0, 5) == 0), target,
                           GAIN_W'($urandom), GAIN_W'($urandom));
            run_phase(45);
            drain();
        end

        $display("Ran %0d samples under %0d register settings, %0d outputs compared.",
                 samples_sent, settings_used, compared);
        $display("Covered bypass, sub-sample to maximum delay targets, gains past unity, "
                 , "and a %0d-cycle output stall.", HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
